FILE: src/ipid_pkg.sv
// ----------------------------------------------------------------------------
// ipid_pkg - shared types and constants for the incremental PID controller
// Control word layout, microprogram, register codes and fixed widths.
// ----------------------------------------------------------------------------
package ipid_pkg;

    // Fixed widths of the register port and the drive output
    localparam int COEF_W      = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int DRIVE_W     = 32;

    // Internal sum is wide enough for every parameter value in range
    localparam int SUM_W           = 64;
    localparam int TERM_LIMIT_LOG2 = 60;

    // Quotient bits retired by the divider per cycle
    localparam int DIV_RADIX_BITS = 4;

    // Register reset values
    localparam logic [COEF_W-1:0] RESET_GAIN     = 16'd26;
    localparam logic [COEF_W-1:0] RESET_PERIOD   = 16'd10;
    localparam logic [COEF_W-1:0] RESET_DERIV    = 16'd50;
    localparam logic [COEF_W-1:0] RESET_INTEGRAL = 16'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN,
        REG_PERIOD,
        REG_DERIV,
        REG_INTEGRAL
    } cfg_reg_t;

    // Microprogram step counter
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE       = 4'd0;
    localparam step_t STEP_PROP_MUL   = 4'd1;
    localparam step_t STEP_DER_MUL_K  = 4'd2;
    localparam step_t STEP_DER_MUL_TD = 4'd3;
    localparam step_t STEP_DER_DIV    = 4'd4;
    localparam step_t STEP_DER_WAIT   = 4'd5;
    localparam step_t STEP_DER_ADD    = 4'd6;
    localparam step_t STEP_INT_MUL_T0 = 4'd7;
    localparam step_t STEP_INT_DIV    = 4'd8;
    localparam step_t STEP_INT_WAIT   = 4'd9;
    localparam step_t STEP_INT_ADD    = 4'd10;
    localparam step_t STEP_FINISH     = 4'd11;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_BEAT,
        COND_DIV_DONE,
        COND_OUT_FREE
    } cond_t;

    typedef enum logic [1:0] {
        A_D1,
        A_D2,
        A_E1,
        A_PROD
    } opa_sel_t;

    typedef enum logic [1:0] {
        B_GAIN,
        B_DERIV,
        B_PERIOD
    } opb_sel_t;

    typedef enum logic [1:0] {
        SUM_HOLD,
        SUM_LOAD_PROP,
        SUM_ADD_TERM
    } sum_op_t;

    typedef enum logic {
        DIV_BY_PERIOD,
        DIV_BY_INTEGRAL
    } div_sel_t;

    typedef struct packed {
        cond_t    cond;
        step_t    target;
        logic     mul_en;
        opa_sel_t a_sel;
        opb_sel_t b_sel;
        sum_op_t  sum_op;
        logic     div_start;
        div_sel_t div_sel;
        logic     finish;
    } ucode_t;

    localparam ucode_t UC_NOP = '{
        cond: COND_ALWAYS, target: STEP_IDLE, mul_en: 1'b0, a_sel: A_D1,
        b_sel: B_GAIN, sum_op: SUM_HOLD, div_start: 1'b0,
        div_sel: DIV_BY_PERIOD, finish: 1'b0
    };

    // Control store: one word per step, jump taken when cond holds
    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        w = UC_NOP;
        unique case (s)
            STEP_IDLE: begin
                w.cond   = COND_IN_BEAT;
                w.target = STEP_PROP_MUL;
            end
            STEP_PROP_MUL: begin
                w.target = STEP_DER_MUL_K;
                w.mul_en = 1'b1;
                w.a_sel  = A_D1;
                w.b_sel  = B_GAIN;
            end
            STEP_DER_MUL_K: begin
                w.target = STEP_DER_MUL_TD;
                w.mul_en = 1'b1;
                w.a_sel  = A_D2;
                w.b_sel  = B_GAIN;
                w.sum_op = SUM_LOAD_PROP;
            end
            STEP_DER_MUL_TD: begin
                w.target = STEP_DER_DIV;
                w.mul_en = 1'b1;
                w.a_sel  = A_PROD;
                w.b_sel  = B_DERIV;
            end
            STEP_DER_DIV: begin
                w.target    = STEP_DER_WAIT;
                w.div_start = 1'b1;
                w.div_sel   = DIV_BY_PERIOD;
            end
            STEP_DER_WAIT: begin
                w.cond   = COND_DIV_DONE;
                w.target = STEP_DER_ADD;
            end
            STEP_DER_ADD: begin
                w.target = STEP_INT_MUL_T0;
                w.sum_op = SUM_ADD_TERM;
                w.mul_en = 1'b1;
                w.a_sel  = A_E1;
                w.b_sel  = B_GAIN;
            end
            STEP_INT_MUL_T0: begin
                w.target = STEP_INT_DIV;
                w.mul_en = 1'b1;
                w.a_sel  = A_PROD;
                w.b_sel  = B_PERIOD;
            end
            STEP_INT_DIV: begin
                w.target    = STEP_INT_WAIT;
                w.div_start = 1'b1;
                w.div_sel   = DIV_BY_INTEGRAL;
            end
            STEP_INT_WAIT: begin
                w.cond   = COND_DIV_DONE;
                w.target = STEP_INT_ADD;
            end
            STEP_INT_ADD: begin
                w.target = STEP_FINISH;
                w.sum_op = SUM_ADD_TERM;
            end
            STEP_FINISH: begin
                w.cond   = COND_OUT_FREE;
                w.target = STEP_IDLE;
                w.finish = 1'b1;
            end
            default: begin
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: src/incremental_pid_controller_top.sv
// ----------------------------------------------------------------------------
// incremental_pid_controller_top - velocity-form discrete PID controller
// Microcoded sequencer over one shared multiplier and one radix-16 divider.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid/in_ready carries one error sample (Q7.8) per beat.
//   Output channel out_valid/out_ready carries the new drive value (Q15.16)
//   and a flag that is set when the accumulator clipped at a limit.
//   cfg_en/cfg_index/cfg_data write gain, sample period, derivative time and
//   integral time; write only while the block is idle. Unknown indexes are
//   ignored; a zero period or integral time is treated as one.
// Sequence
//   One item at a time. From the accepting edge the sequencer forms the
//   proportional product, the derivative term and the integral term (each
//   two products and a division), then loads the clipped sum into the
//   output register. Each divider pass retires four quotient bits a cycle.
// Reset and stall
//   Reset clears the error history and accumulator and reloads the register
//   defaults. A finished result waits in the output register; the next
//   sample is accepted and worked on meanwhile, and the sequencer holds at
//   its last step only if the previous result has still not been taken.
// ----------------------------------------------------------------------------
module incremental_pid_controller_top
    import ipid_pkg::*;
#(
    parameter int ERROR_WIDTH = 16,
    parameter int ACCUM_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_en,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [COEF_W-1:0]             cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [ERROR_WIDTH-1:0] error_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [DRIVE_W-1:0]     drive_value,
    output logic                          saturated
);

    localparam int EW        = ERROR_WIDTH;
    localparam int AW        = ACCUM_WIDTH;
    localparam int MA        = EW + 17;                 // multiplier operand A
    localparam int DW        = MA + COEF_W;             // product / dividend
    localparam int PW        = ((DW + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS)
                               * DIV_RADIX_BITS;
    localparam int DIV_STEPS = PW / DIV_RADIX_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int MW        = ((PW > TERM_LIMIT_LOG2 + 1) ? PW : TERM_LIMIT_LOG2 + 1) + 1;

    localparam logic [MW-1:0]    TERM_LIM = MW'(1) << TERM_LIMIT_LOG2;
    localparam logic [SUM_W-1:0] ACC_HI   = (SUM_W'(1) << (AW - 1)) - SUM_W'(1);
    localparam logic [SUM_W-1:0] ACC_LO   = ~ACC_HI;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    step_t                  step_reg, step_next;

    logic [COEF_W-1:0]      gain_reg, gain_next;
    logic [COEF_W-1:0]      period_reg, period_next;
    logic [COEF_W-1:0]      deriv_reg, deriv_next;
    logic [COEF_W-1:0]      integral_reg, integral_next;

    logic signed [EW-1:0]   e_reg, e_next;
    logic signed [EW-1:0]   e1_reg, e1_next;
    logic signed [EW-1:0]   e2_reg, e2_next;
    logic signed [AW-1:0]   accum_reg, accum_next;

    logic [DW-1:0]          prod_reg, prod_next;
    logic                   sign_reg, sign_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;

    logic                   div_busy_reg, div_busy_next;
    logic [CNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic [PW-1:0]          div_q_reg, div_q_next;
    logic [COEF_W-1:0]      div_rem_reg, div_rem_next;
    logic [COEF_W-1:0]      div_d_reg, div_d_next;

    logic                   out_valid_reg, out_valid_next;
    logic [DRIVE_W-1:0]     drive_reg, drive_next;
    logic                   sat_reg, sat_next;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    ucode_t ctrl;
    logic   in_beat;
    logic   out_free;
    logic   cond_ok;
    logic   finish_fire;

    assign ctrl        = ucode_rom(step_reg);
    assign in_ready    = (ctrl.cond == COND_IN_BEAT);
    assign in_beat     = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign finish_fire = ctrl.finish && out_free;

    always_comb
    begin
        case (ctrl.cond)
            COND_ALWAYS:   cond_ok = 1'b1;
            COND_IN_BEAT:  cond_ok = in_valid;
            COND_DIV_DONE: cond_ok = !div_busy_reg;
            COND_OUT_FREE: cond_ok = out_free;
            default:       cond_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (cond_ok)
        begin
            step_next = ctrl.target;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic [COEF_W-1:0]      t0_eff;
    logic [COEF_W-1:0]      ti_eff;
    logic signed [EW:0]     d1;
    logic signed [EW+1:0]   d2;
    logic [EW:0]            d1_mag;
    logic [EW+1:0]          d2_mag;
    logic [EW-1:0]          e1_mag;
    logic [MA-1:0]          mul_a;
    logic [COEF_W-1:0]      mul_b;
    logic                   mul_sign;
    logic [DW-1:0]          mul_p;

    assign t0_eff = (period_reg == '0) ? COEF_W'(1) : period_reg;
    assign ti_eff = (integral_reg == '0) ? COEF_W'(1) : integral_reg;

    // e - e1 and e - 2*e1 + e2
    assign d1     = (EW+1)'(e_reg) - (EW+1)'(e1_reg);
    assign d2     = (EW+2)'(e_reg) - ((EW+2)'(e1_reg) <<< 1) + (EW+2)'(e2_reg);
    assign d1_mag = d1[EW] ? (~d1 + 1'b1) : d1;
    assign d2_mag = d2[EW+1] ? (~d2 + 1'b1) : d2;
    assign e1_mag = e1_reg[EW-1] ? (~e1_reg + 1'b1) : e1_reg;

    always_comb
    begin
        case (ctrl.a_sel)
            A_D1:
            begin
                mul_a    = MA'(d1_mag);
                mul_sign = d1[EW];
            end
            A_D2:
            begin
                mul_a    = MA'(d2_mag);
                mul_sign = d2[EW+1];
            end
            A_E1:
            begin
                mul_a    = MA'(e1_mag);
                mul_sign = e1_reg[EW-1];
            end
            default:
            begin
                mul_a    = prod_reg[MA-1:0];
                mul_sign = sign_reg;
            end
        endcase
    end

    always_comb
    begin
        case (ctrl.b_sel)
            B_GAIN:   mul_b = gain_reg;
            B_DERIV:  mul_b = deriv_reg;
            B_PERIOD: mul_b = t0_eff;
            default:  mul_b = gain_reg;
        endcase
    end

    assign mul_p = DW'(mul_a) * DW'(mul_b);

    // Divider: DIV_RADIX_BITS restoring steps per cycle, dividend shifts out
    // of the top of div_q_reg while quotient bits enter at the bottom
    logic [PW-1:0]     radix_q;
    logic [COEF_W-1:0] radix_rem;

    always_comb
    begin
        logic [COEF_W:0] trial;
        radix_q   = div_q_reg;
        radix_rem = div_rem_reg;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            trial = {radix_rem, radix_q[PW-1]};
            if (trial >= {1'b0, div_d_reg})
            begin
                radix_rem = COEF_W'(trial - {1'b0, div_d_reg});
                radix_q   = {radix_q[PW-2:0], 1'b1};
            end
            else
            begin
                radix_rem = trial[COEF_W-1:0];
                radix_q   = {radix_q[PW-2:0], 1'b0};
            end
        end
    end

    // Round to nearest, ties away from zero, then clamp the magnitude
    logic             round_up;
    logic [MW-1:0]    q_mag;
    logic [MW-1:0]    term_mag;
    logic [SUM_W-1:0] term_abs;
    logic [SUM_W-1:0] term_s;
    logic [SUM_W-1:0] prop_abs;
    logic [SUM_W-1:0] prop_s;
    logic [SUM_W-1:0] accum_ext;

    assign round_up  = ({div_rem_reg, 1'b0} >= {1'b0, div_d_reg});
    assign q_mag     = MW'(div_q_reg) + MW'(round_up);
    assign term_mag  = (q_mag > TERM_LIM) ? TERM_LIM : q_mag;
    assign term_abs  = SUM_W'(term_mag);
    assign term_s    = sign_reg ? (~term_abs + 1'b1) : term_abs;
    assign prop_abs  = SUM_W'(prod_reg[EW+16:0]);
    assign prop_s    = sign_reg ? (~prop_abs + 1'b1) : prop_abs;
    assign accum_ext = {{(SUM_W-AW){accum_reg[AW-1]}}, accum_reg};

    // Clip to the accumulator range
    logic [SUM_W-AW:0] sum_top;
    logic              in_range;
    logic [SUM_W-1:0]  clip_val;

    assign sum_top  = sum_reg[SUM_W-1:AW-1];
    assign in_range = (&sum_top) || !(|sum_top);
    assign clip_val = in_range ? sum_reg : (sum_reg[SUM_W-1] ? ACC_LO : ACC_HI);

    always_comb
    begin
        gain_next     = gain_reg;
        period_next   = period_reg;
        deriv_next    = deriv_reg;
        integral_next = integral_reg;
        if (cfg_en)
        begin
            unique case (cfg_index)
                REG_GAIN:     gain_next     = cfg_data;
                REG_PERIOD:   period_next   = cfg_data;
                REG_DERIV:    deriv_next    = cfg_data;
                REG_INTEGRAL: integral_next = cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        e_next     = e_reg;
        e1_next    = e1_reg;
        e2_next    = e2_reg;
        accum_next = accum_reg;
        prod_next  = prod_reg;
        sign_next  = sign_reg;
        sum_next   = sum_reg;

        if (in_beat)
        begin
            e_next = error_sample;
        end

        if (ctrl.mul_en)
        begin
            prod_next = mul_p;
            sign_next = mul_sign;
        end

        case (ctrl.sum_op)
            SUM_LOAD_PROP: sum_next = accum_ext + prop_s;
            SUM_ADD_TERM:  sum_next = sum_reg + term_s;
            default:       ;
        endcase

        if (finish_fire)
        begin
            accum_next = clip_val[AW-1:0];
            e2_next    = e1_reg;
            e1_next    = e_reg;
        end
    end

    always_comb
    begin
        div_busy_next = div_busy_reg;
        div_cnt_next  = div_cnt_reg;
        div_q_next    = div_q_reg;
        div_rem_next  = div_rem_reg;
        div_d_next    = div_d_reg;
        if (ctrl.div_start)
        begin
            div_busy_next = 1'b1;
            div_cnt_next  = CNT_W'(DIV_STEPS);
            div_q_next    = PW'(prod_reg);
            div_rem_next  = '0;
            div_d_next    = (ctrl.div_sel == DIV_BY_INTEGRAL) ? ti_eff : t0_eff;
        end
        else if (div_busy_reg)
        begin
            div_q_next    = radix_q;
            div_rem_next  = radix_rem;
            div_cnt_next  = div_cnt_reg - 1'b1;
            div_busy_next = (div_cnt_reg != CNT_W'(1));
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        drive_next     = drive_reg;
        sat_next       = sat_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (finish_fire)
        begin
            out_valid_next = 1'b1;
            drive_next     = clip_val[DRIVE_W-1:0];
            sat_next       = !in_range;
        end
    end

    // ------------------------------------------------------------------
    // Flops
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            gain_reg      <= RESET_GAIN;
            period_reg    <= RESET_PERIOD;
            deriv_reg     <= RESET_DERIV;
            integral_reg  <= RESET_INTEGRAL;
            e1_reg        <= '0;
            e2_reg        <= '0;
            accum_reg     <= '0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            gain_reg      <= gain_next;
            period_reg    <= period_next;
            deriv_reg     <= deriv_next;
            integral_reg  <= integral_next;
            e1_reg        <= e1_next;
            e2_reg        <= e2_next;
            accum_reg     <= accum_next;
            div_busy_reg  <= div_busy_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg       <= e_next;
        prod_reg    <= prod_next;
        sign_reg    <= sign_next;
        sum_reg     <= sum_next;
        div_q_reg   <= div_q_next;
        div_rem_reg <= div_rem_next;
        div_d_reg   <= div_d_next;
        drive_reg   <= drive_next;
        sat_reg     <= sat_next;
    end

    assign out_valid   = out_valid_reg;
    assign drive_value = drive_reg;
    assign saturated   = sat_reg;

endmodule

FILE: src/ipid_checker.sv
// ----------------------------------------------------------------------------
// ipid_checker - port-level assertions for the incremental PID controller
// Bound to the top level; watches the handshakes and the saturated flag.
// ----------------------------------------------------------------------------
module ipid_checker
    import ipid_pkg::*;
#(
    parameter int ACCUM_WIDTH = 32
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [DRIVE_W-1:0] drive_value,
    input logic                      saturated
);

    localparam logic [SUM_W-1:0]   ACC_HI = (SUM_W'(1) << (ACCUM_WIDTH - 1)) - SUM_W'(1);
    localparam logic [SUM_W-1:0]   ACC_LO = ~ACC_HI;
    localparam logic [DRIVE_W-1:0] HI_32  = ACC_HI[DRIVE_W-1:0];
    localparam logic [DRIVE_W-1:0] LO_32  = ACC_LO[DRIVE_W-1:0];

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_value) && $stable(saturated))
        else $error("result beat changed while stalled");

    // A clipped result sits at one of the accumulator limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> drive_value == HI_32 || drive_value == LO_32)
        else $error("saturated flag without limit value");

    // One sample in flight: ready drops after an input beat
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while busy");

    // A new result only appears from a busy sequencer
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

endmodule

bind incremental_pid_controller_top ipid_checker #(
    .ACCUM_WIDTH (ACCUM_WIDTH)
) u_ipid_checker (.*);

FILE: tb/sv/tb_incremental_pid_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_incremental_pid_controller_top - self-checking bench for the PID block
// Error samples go in on a valid/ready channel with random gaps. A local
// velocity-form PID predictor computes each drive value and clip flag. The
// output channel is stalled at random and every result is checked in order.
// Register settings change between drained phases: extremes, zero divisors,
// unused indexes, then random settings.
// ----------------------------------------------------------------------------
module tb_incremental_pid_controller_top
    import ipid_pkg::*;
();

    localparam int ERR_W           = 16;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_ITEMS     = 128;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int REPORT_LIMIT    = 100;
    localparam int FIRST_UNUSED_IX = REG_INTEGRAL + 1;
    localparam int LAST_IX         = (1 << CFG_INDEX_W) - 1;

    localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic [COEF_W-1:0]       COEF_MAX = '1;

    localparam longint      ACC_MAX  = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint      ACC_MIN  = -ACC_MAX - 1;
    localparam logic [95:0] TERM_CAP = 96'd1 << TERM_LIMIT_LOG2;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic                      sat;
    } drive_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COEF_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [ERR_W-1:0] error_sample;
    logic out_valid;
    logic out_ready;
    logic signed [DRIVE_W-1:0] drive_value;
    logic saturated;

    // predictor state and register copy
    logic [COEF_W-1:0]         k_gain;
    logic [COEF_W-1:0]         t0_period;
    logic [COEF_W-1:0]         td_time;
    logic [COEF_W-1:0]         ti_time;
    logic signed [ERR_W-1:0]   prev_err;
    logic signed [ERR_W-1:0]   older_err;
    logic signed [DRIVE_W-1:0] drive_acc;

    logic signed [ERR_W-1:0] pending_errors[$];
    drive_result_t           expected_drive[$];

    int unsigned items_sent;
    int unsigned results_done;
    int unsigned clipped_count;
    int unsigned mismatch_count;
    int unsigned cfg_writes;
    int unsigned settings_count;
    int unsigned idle_cycles;
    int unsigned send_gap;
    int unsigned stall_left;
    bit          in_taken;
    bit          idle_on;
    bit          stall_on;

    incremental_pid_controller_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_en       (cfg_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .error_sample (error_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive_value  (drive_value),
        .saturated    (saturated)
    );

    always #6 clk = ~clk;

    // round(x * factor / divisor), ties away from zero, magnitude capped
    function automatic longint round_ratio(input longint x, input logic [COEF_W-1:0] factor,
                                           input logic [COEF_W-1:0] divisor);
        logic [95:0] mag;
        logic [95:0] prod;
        logic [95:0] quo;
        logic [95:0] rem;
        logic [95:0] div96;
        bit          neg;
        neg   = (x < 0);
        mag   = neg ? 96'(-x) : 96'(x);
        div96 = {80'd0, divisor};
        prod  = mag * {80'd0, factor};
        quo   = prod / div96;
        rem   = prod % div96;
        mag   = quo + (((rem << 1) >= div96) ? 96'd1 : 96'd0);
        if (mag > TERM_CAP)
            mag = TERM_CAP;
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic drive_result_t next_drive(input logic signed [ERR_W-1:0] err);
        longint            e;
        longint            e1;
        longint            e2;
        longint            k;
        longint            sum;
        logic [COEF_W-1:0] t0;
        logic [COEF_W-1:0] ti;
        drive_result_t     res;
        e  = err;
        e1 = prev_err;
        e2 = older_err;
        k  = {48'd0, k_gain};
        t0 = (t0_period == '0) ? COEF_W'(1) : t0_period;
        ti = (ti_time == '0) ? COEF_W'(1) : ti_time;
        sum = longint'(drive_acc) + k * (e - e1)
            + round_ratio(k * (e - 2 * e1 + e2), td_time, t0)
            + round_ratio(k * e1, t0, ti);
        res.sat = 1'b0;
        if (sum > ACC_MAX)
        begin
            sum     = ACC_MAX;
            res.sat = 1'b1;
        end
        else if (sum < ACC_MIN)
        begin
            sum     = ACC_MIN;
            res.sat = 1'b1;
        end
        res.drive = sum[DRIVE_W-1:0];
        drive_acc = sum[DRIVE_W-1:0];
        older_err = prev_err;
        prev_err  = err;
        return res;
    endfunction

    // mostly back to back, some short gaps, the odd long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic signed [ERR_W-1:0] pick_error();
        int unsigned r;
        r = $urandom_range(0, 19);
        case (r)
            0: return ERR_MAX;
            1: return ERR_MIN;
            2: return '0;
            3, 4, 5: return ERR_W'(int'($urandom_range(0, 1023)) - 512);
            default: return ERR_W'($urandom());
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(input int unsigned typical_max);
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return COEF_MAX;
            2, 3: return COEF_W'($urandom());
            default: return COEF_W'($urandom_range(1, typical_max));
        endcase
    endfunction

    function automatic void queue_error(input logic signed [ERR_W-1:0] err);
        pending_errors.push_back(err);
        items_sent++;
    endfunction

    task automatic wait_drained();
        while (results_done != items_sent)
            @(negedge clk);
        // block is idle once the last result is out; margin for latency
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] ix, input logic [COEF_W-1:0] val);
        @(negedge clk);
        cfg_en    <= 1'b1;
        cfg_index <= ix;
        cfg_data  <= val;
        cfg_writes++;
        case (ix)
            REG_GAIN:     k_gain    = val;
            REG_PERIOD:   t0_period = val;
            REG_DERIV:    td_time   = val;
            REG_INTEGRAL: ti_time   = val;
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(negedge clk);
        cfg_en <= 1'b0;
        settings_count++;
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            in_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_errors.size() > 0)
            begin
                error_sample <= pending_errors.pop_front();
                in_valid     <= 1'b1;
                send_gap = idle_on ? pick_gap() : 0;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (stall_on && $urandom_range(0, 5) == 0)
                stall_left = pick_gap();
        end
    end

    // prediction on input beats, checking on output beats, watchdog
    always @(posedge clk)
    begin : drive_check
        drive_result_t want;
        bit            any_beat;
        if (rst_n)
        begin
            any_beat = 1'b0;
            if (in_valid && in_ready)
            begin
                expected_drive.push_back(next_drive(error_sample));
                in_taken = 1'b1;
                any_beat = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                any_beat = 1'b1;
                if (expected_drive.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, drive %h sat %b",
                             $time, drive_value, saturated);
                    $display("tb_incremental_pid_controller_top failed");
                    $finish;
                end
                else
                begin
                    want = expected_drive.pop_front();
                    results_done++;
                    if (want.sat)
                        clipped_count++;
                    if (drive_value !== want.drive || saturated !== want.sat)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: expected drive %h sat %b, actual drive %h sat %b",
                                     $time, want.drive, want.sat, drive_value, saturated);
                    end
                end
            end
            idle_cycles = any_beat ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb_incremental_pid_controller_top failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned n;
        rst_n        = 1'b0;
        cfg_en       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        error_sample = '0;
        out_ready    = 1'b0;
        in_taken     = 1'b0;
        idle_on      = 1'b1;
        stall_on     = 1'b1;
        send_gap     = 0;
        stall_left   = 0;
        idle_cycles  = 0;
        items_sent   = 0;
        results_done = 0;
        k_gain       = RESET_GAIN;
        t0_period    = RESET_PERIOD;
        td_time      = RESET_DERIV;
        ti_time      = RESET_INTEGRAL;
        prev_err     = '0;
        older_err    = '0;
        drive_acc    = '0;
        settings_count = 1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults
        queue_error(ERR_MAX);
        queue_error(ERR_MIN);
        queue_error('0);
        queue_error(ERR_W'(1));
        queue_error(-ERR_W'(1));
        queue_error(ERR_MAX);
        wait_drained();

        // largest terms: clips high, then low
        write_reg(REG_GAIN, COEF_MAX);
        write_reg(REG_PERIOD, COEF_W'(1));
        write_reg(REG_DERIV, COEF_MAX);
        write_reg(REG_INTEGRAL, COEF_W'(1));
        close_writes();
        queue_error(ERR_MAX);
        queue_error(ERR_MAX);
        queue_error(ERR_MIN);
        queue_error(ERR_MIN);
        queue_error('0);
        queue_error('0);
        wait_drained();

        // zero period and integral time read as one
        write_reg(REG_GAIN, COEF_W'(256));
        write_reg(REG_PERIOD, '0);
        write_reg(REG_DERIV, COEF_W'(1));
        write_reg(REG_INTEGRAL, '0);
        close_writes();
        queue_error(ERR_W'(256));
        queue_error(-ERR_W'(256));
        queue_error(ERR_W'(1000));
        queue_error(ERR_MIN);
        wait_drained();

        // unused indexes must leave the registers alone
        write_reg(CFG_INDEX_W'(FIRST_UNUSED_IX), COEF_MAX);
        write_reg(CFG_INDEX_W'(LAST_IX), '0);
        write_reg(REG_GAIN, COEF_W'(1));
        write_reg(REG_PERIOD, COEF_MAX);
        write_reg(REG_DERIV, '0);
        write_reg(REG_INTEGRAL, COEF_MAX);
        close_writes();
        queue_error(ERR_MAX);
        queue_error(ERR_MIN);
        queue_error(ERR_W'(12345));
        queue_error(-ERR_W'(4321));
        queue_error('0);
        wait_drained();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_GAIN, pick_coef(512));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_PERIOD, pick_coef(50));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_DERIV, pick_coef(100));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_INTEGRAL, pick_coef(200));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(FIRST_UNUSED_IX, LAST_IX)),
                          COEF_W'($urandom()));
            close_writes();
            // every third phase runs flat out on both sides
            idle_on  = (phase % 3 != 0);
            stall_on = (phase % 3 != 0);
            for (n = 0; n < PHASE_ITEMS; n++)
                queue_error(pick_error());
            wait_drained();
        end

        $display("Covered %0d error samples over %0d register settings (%0d register writes).",
                 items_sent, settings_count, cfg_writes);
        $display("Checked %0d drive results, %0d of them clipped; %0d mismatches.",
                 results_done, clipped_count, mismatch_count);
        if (mismatch_count == 0 && expected_drive.size() == 0)
            $display("tb_incremental_pid_controller_top passed");
        else
            $display("tb_incremental_pid_controller_top failed");
        $finish;
    end

endmodule
